>>> sv/mdss_pkg.sv
// package: types, constants and address-map helpers of the data-space stack unit
package mdss_pkg;

  localparam logic [15:0] TOP_ADDRESS = 16'h08FF;
  localparam logic [15:0] STACK_FLOOR = 16'h0100;
  localparam int unsigned REG_COUNT   = 32;
  localparam int unsigned REG_AW      = $clog2(REG_COUNT);
  localparam int unsigned MEM_DEPTH   = int'(TOP_ADDRESS) + 1;
  localparam int unsigned MEM_AW      = $clog2(MEM_DEPTH);

  localparam logic [15:0] ADDR_SPL    = 16'h005D;
  localparam logic [15:0] ADDR_SPH    = 16'h005E;
  localparam logic [15:0] ADDR_SREG   = 16'h005F;
  localparam logic [15:0] IO_BASE     = 16'h0020;
  localparam logic [7:0]  UART_HI_LO  = 8'hC0;
  localparam logic [7:0]  UART_HI_TOP = 8'hC6;
  localparam logic [7:0]  UART_LO_LO  = 8'h29;
  localparam logic [7:0]  UART_LO_TOP = 8'h2D;
  localparam logic [7:0]  TMR_A       = 8'h35;
  localparam logic [7:0]  TMR_B_LO    = 8'h44;
  localparam logic [7:0]  TMR_B_TOP   = 8'h48;
  localparam logic [7:0]  TMR_C       = 8'h6E;

  localparam logic [1:0] PT_NONE  = 2'd0;
  localparam logic [1:0] PT_TIMER = 2'd1;
  localparam logic [1:0] PT_UART  = 2'd2;

  typedef enum logic [3:0] {
    OP_READ   = 4'd0,
    OP_WRITE  = 4'd1,
    OP_PUSH   = 4'd2,
    OP_POP    = 4'd3,
    OP_PUSHW  = 4'd4,
    OP_POPW   = 4'd5,
    OP_SETBIT = 4'd6,
    OP_CLRBIT = 4'd7,
    OP_CLRF   = 4'd8
  } op_t;

  typedef enum logic [3:0] {
    ACC_NONE,
    ACC_RD,
    ACC_WR,
    ACC_PUSH_LO,
    ACC_PUSH_HI,
    ACC_POP,
    ACC_BIT_RD,
    ACC_BIT_WR,
    ACC_CLRF
  } acc_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIRST,
    ST_TAKE1,
    ST_SECOND,
    ST_TAKE2,
    ST_DONE
  } st_t;

  typedef struct packed {
    logic clear;
    logic cap;
    acc_t acc;
    logic take;
    logic load;
  } ctl_cmd_t;

  typedef struct packed {
    logic [3:0] op;
    logic       clr_done;
    logic       out_free;
  } ctl_sts_t;

  function automatic logic [1:0] periph_tgt(input logic [15:0] a);
    logic [1:0] t;
    t = PT_NONE;
    if (a[15:8] == 8'h00) begin
      if (a[7:0] == TMR_A || (a[7:0] >= TMR_B_LO && a[7:0] <= TMR_B_TOP) || a[7:0] == TMR_C) begin
        t = PT_TIMER;
      end else if ((a[7:0] >= UART_HI_LO && a[7:0] <= UART_HI_TOP) ||
                   (a[7:0] >= UART_LO_LO && a[7:0] <= UART_LO_TOP)) begin
        t = PT_UART;
      end
    end
    return t;
  endfunction

  function automatic logic [7:0] periph_off(input logic [15:0] a);
    logic [7:0] o;
    if (a[7:0] >= UART_HI_LO) begin
      o = a[7:0] - UART_HI_LO;
    end else begin
      o = a[7:0] - IO_BASE[7:0];
    end
    return o;
  endfunction

endpackage

>>> sv/mdss_ctrl.sv
// controller: sequences the memory clear and the byte accesses of each transaction
module mdss_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mdss_pkg::ctl_sts_t sts,
  output mdss_pkg::ctl_cmd_t cmd
);
  import mdss_pkg::*;

  st_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_FIRST;
      end
      ST_FIRST: begin
        case (sts.op)
          OP_READ, OP_POP, OP_POPW:       state_nxt = ST_TAKE1;
          OP_PUSHW, OP_SETBIT, OP_CLRBIT: state_nxt = ST_SECOND;
          default:                        state_nxt = ST_DONE;
        endcase
      end
      ST_TAKE1: begin
        state_nxt = (sts.op == OP_POPW) ? ST_SECOND : ST_DONE;
      end
      ST_SECOND: begin
        state_nxt = (sts.op == OP_POPW) ? ST_TAKE2 : ST_DONE;
      end
      ST_TAKE2: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.acc  = ACC_NONE;
    in_stall = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.cap  = in_valid;
      end
      ST_FIRST: begin
        case (sts.op)
          OP_READ:             cmd.acc = ACC_RD;
          OP_WRITE:            cmd.acc = ACC_WR;
          OP_PUSH, OP_PUSHW:   cmd.acc = ACC_PUSH_LO;
          OP_POP, OP_POPW:     cmd.acc = ACC_POP;
          OP_SETBIT, OP_CLRBIT: cmd.acc = ACC_BIT_RD;
          OP_CLRF:             cmd.acc = ACC_CLRF;
          default:             cmd.acc = ACC_NONE;
        endcase
      end
      ST_TAKE1, ST_TAKE2: begin
        cmd.take = 1'b1;
      end
      ST_SECOND: begin
        case (sts.op)
          OP_PUSHW:             cmd.acc = ACC_PUSH_HI;
          OP_POPW:              cmd.acc = ACC_POP;
          OP_SETBIT, OP_CLRBIT: cmd.acc = ACC_BIT_WR;
          default:              cmd.acc = ACC_NONE;
        endcase
      end
      ST_DONE: begin
        cmd.load = sts.out_free;
      end
      default: begin
        cmd.acc = ACC_NONE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> sts.out_free) else $error("result loaded into a busy output");
  a_cap_first: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cap |=> state_r == ST_FIRST) else $error("captured transaction not started");
  a_no_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !cmd.cap && cmd.acc == ACC_NONE)
    else $error("access during memory clear");
`endif

endmodule

>>> sv/mdss_dpath.sv
// datapath: register file, data memory, stack pointer, fault flag and result register
module mdss_dpath (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [3:0]         in_opcode,
  input  logic [15:0]        in_address,
  input  logic [15:0]        in_data,
  input  logic [2:0]         in_bit_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_read_data,
  output logic               out_fault_now,
  output logic               out_fault_pending,
  output logic [1:0]         out_periph_target,
  output logic               out_periph_write,
  output logic [7:0]         out_periph_offset,
  output logic [7:0]         out_periph_data,
  output logic [15:0]        out_stack_pointer,
  input  mdss_pkg::ctl_cmd_t cmd,
  output mdss_pkg::ctl_sts_t sts
);
  import mdss_pkg::*;

  logic [7:0]        mem [MEM_DEPTH];
  logic [7:0]        rf_r [REG_COUNT];
  logic [MEM_AW-1:0] clr_cnt_r;
  logic [7:0]        mem_q_r;
  logic [7:0]        nm_r, nm_nxt;
  logic              src_mem_r;

  logic [3:0]  op_r;
  logic [15:0] addr_r, data_r;
  logic [2:0]  bit_r;

  logic [15:0] sp_r, sp_nxt;
  logic [7:0]  sreg_r, sreg_nxt;
  logic        fault_r, fault_nxt;
  logic        sfault_r, sfault_nxt;
  logic [15:0] rd_r, rd_nxt;
  logic [1:0]  pt_r, pt_nxt;
  logic        pw_r, pw_nxt;
  logic [7:0]  po_r, po_nxt;
  logic [7:0]  pd_r, pd_nxt;
  logic        out_valid_r;

  logic [15:0] acc_a, sp_inc, sp_acc;
  logic [7:0]  acc_v, rbyte, mask;
  logic        is_rd, is_wr, is_push, is_pop, bound_bad, go;
  logic        a_reg, a_spl, a_sph, a_sr, a_per, a_bad, a_mem;
  logic [1:0]  tgt;
  logic        mem_we, mem_re;
  logic [MEM_AW-1:0] mem_a;
  logic [7:0]  mem_wd;

  assign rbyte  = src_mem_r ? mem_q_r : nm_r;
  assign mask   = 8'b1 << bit_r;
  assign sp_inc = sp_r + 16'd1;

  always_comb begin
    is_rd   = 1'b0;
    is_wr   = 1'b0;
    is_push = 1'b0;
    is_pop  = 1'b0;
    acc_a   = addr_r;
    acc_v   = data_r[7:0];
    case (cmd.acc)
      ACC_RD: begin
        is_rd = 1'b1;
      end
      ACC_WR: begin
        is_wr = 1'b1;
      end
      ACC_PUSH_LO: begin
        is_wr   = 1'b1;
        is_push = 1'b1;
        acc_a   = sp_r;
      end
      ACC_PUSH_HI: begin
        is_wr   = 1'b1;
        is_push = 1'b1;
        acc_a   = sp_r;
        acc_v   = data_r[15:8];
      end
      ACC_POP: begin
        is_rd  = 1'b1;
        is_pop = 1'b1;
        acc_a  = sp_inc;
      end
      ACC_BIT_RD: begin
        is_rd = 1'b1;
        acc_a = IO_BASE + {10'd0, addr_r[5:0]};
      end
      ACC_BIT_WR: begin
        is_wr = 1'b1;
        acc_a = IO_BASE + {10'd0, addr_r[5:0]};
        acc_v = (op_r == OP_SETBIT) ? (rbyte | mask) : (rbyte & ~mask);
      end
      default: begin
        is_rd = 1'b0;
      end
    endcase
  end

  assign bound_bad = (is_push && (sp_r < STACK_FLOOR || sp_r > TOP_ADDRESS)) ||
                     (is_pop && (sp_r >= TOP_ADDRESS));
  assign go     = (is_rd || is_wr) && !bound_bad;
  assign sp_acc = is_pop ? sp_inc : sp_r;

  // address map in priority order
  assign tgt   = periph_tgt(acc_a);
  assign a_reg = acc_a < 16'(REG_COUNT);
  assign a_spl = acc_a == ADDR_SPL;
  assign a_sph = acc_a == ADDR_SPH;
  assign a_sr  = acc_a == ADDR_SREG;
  assign a_per = !a_reg && !a_spl && !a_sph && !a_sr && tgt != PT_NONE;
  assign a_bad = !a_reg && !a_spl && !a_sph && !a_sr && !a_per && acc_a > TOP_ADDRESS;
  assign a_mem = !a_reg && !a_spl && !a_sph && !a_sr && !a_per && !a_bad;

  always_comb begin
    nm_nxt = 8'd0;
    if (a_reg) begin
      nm_nxt = rf_r[acc_a[REG_AW-1:0]];
    end else if (a_spl) begin
      nm_nxt = sp_acc[7:0];
    end else if (a_sph) begin
      nm_nxt = sp_acc[15:8];
    end else if (a_sr) begin
      nm_nxt = sreg_r;
    end
  end

  always_comb begin
    sp_nxt     = sp_r;
    sreg_nxt   = sreg_r;
    fault_nxt  = fault_r;
    sfault_nxt = sfault_r;
    rd_nxt     = rd_r;
    pt_nxt     = pt_r;
    pw_nxt     = pw_r;
    po_nxt     = po_r;
    pd_nxt     = pd_r;
    if (cmd.cap) begin
      sfault_nxt = 1'b0;
      rd_nxt     = 16'd0;
      pt_nxt     = PT_NONE;
      pw_nxt     = 1'b0;
      po_nxt     = 8'd0;
      pd_nxt     = 8'd0;
    end
    if (cmd.take) begin
      rd_nxt = {rd_r[7:0], rbyte};
    end
    if (cmd.acc == ACC_CLRF) begin
      fault_nxt = 1'b0;
    end
    if (bound_bad || (go && a_bad)) begin
      fault_nxt  = 1'b1;
      sfault_nxt = 1'b1;
    end
    if (go && a_per) begin
      pt_nxt = tgt;
      pw_nxt = is_wr;
      po_nxt = periph_off(acc_a);
      pd_nxt = is_wr ? acc_v : 8'd0;
    end
    if (go && is_push) begin
      sp_nxt = sp_r - 16'd1;
    end else if (go && is_pop) begin
      sp_nxt = sp_inc;
    end else if (go && is_wr && a_spl) begin
      sp_nxt = {sp_r[15:8], acc_v};
    end else if (go && is_wr && a_sph) begin
      sp_nxt = {acc_v, sp_r[7:0]};
    end
    if (go && is_wr && a_sr) begin
      sreg_nxt = acc_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r      <= TOP_ADDRESS;
      sreg_r    <= 8'd0;
      fault_r   <= 1'b0;
      clr_cnt_r <= '0;
    end else begin
      sp_r    <= sp_nxt;
      sreg_r  <= sreg_nxt;
      fault_r <= fault_nxt;
      if (cmd.clear) clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    sfault_r <= sfault_nxt;
    rd_r     <= rd_nxt;
    pt_r     <= pt_nxt;
    pw_r     <= pw_nxt;
    po_r     <= po_nxt;
    pd_r     <= pd_nxt;
    if (cmd.cap) begin
      op_r   <= in_opcode;
      addr_r <= in_address;
      data_r <= in_data;
      bit_r  <= in_bit_index;
    end
    if (go && is_rd) begin
      nm_r      <= nm_nxt;
      src_mem_r <= a_mem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) rf_r[i] <= 8'd0;
    end else if (go && is_wr && a_reg) begin
      rf_r[acc_a[REG_AW-1:0]] <= acc_v;
    end
  end

  // single-port data memory, shared with the clearing pass
  assign mem_we = cmd.clear || (go && is_wr && a_mem);
  assign mem_re = go && is_rd && a_mem;
  assign mem_a  = cmd.clear ? clr_cnt_r : acc_a[MEM_AW-1:0];
  assign mem_wd = cmd.clear ? 8'd0 : acc_v;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_a] <= mem_wd;
    if (mem_re) mem_q_r <= mem[mem_a];
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_read_data     <= sfault_r ? 16'd0 : rd_r;
      out_fault_now     <= sfault_r;
      out_fault_pending <= fault_r;
      out_periph_target <= pt_r;
      out_periph_write  <= pw_r;
      out_periph_offset <= po_r;
      out_periph_data   <= pd_r;
      out_stack_pointer <= sp_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign sts.op       = op_r;
  assign sts.clr_done = clr_cnt_r == MEM_AW'(MEM_DEPTH - 1);
  assign sts.out_free = !out_valid_r || !out_stall;

`ifndef SYNTHESIS
  a_bound_sp: assert property (@(posedge clk) disable iff (!rst_n)
    bound_bad |=> $stable(sp_r)) else $error("stack pointer moved on bound fault");
  a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fault_now |-> out_fault_pending) else $error("fault not sticky");
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fault_now |-> out_read_data == 16'd0)
    else $error("read data not zero on fault");
`endif

endmodule

>>> sv/mcu_data_space_stack_unit.sv
// top level of the data-space stack unit: controller plus datapath
//
//   channel  valid      stall      payload
//   in       in_valid   in_stall   in_opcode in_address in_data in_bit_index
//   out      out_valid  out_stall  out_read_data out_fault_now out_fault_pending
//                                  out_periph_* out_stack_pointer
//
// one transaction at a time; write, push: one byte access; clear fault, unused opcodes: none;
// read, pop: one access and a take; word push, bit set/clear: two accesses; word pop: two of each
// each byte access makes at most one pass through the single-port data memory
// after reset the memory is cleared one byte a cycle, all 2304 bytes, with in_stall high
// a finished result waits in the output register while out_stall is high
module mcu_data_space_stack_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_opcode,
  input  logic [15:0] in_address,
  input  logic [15:0] in_data,
  input  logic [2:0]  in_bit_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_read_data,
  output logic        out_fault_now,
  output logic        out_fault_pending,
  output logic [1:0]  out_periph_target,
  output logic        out_periph_write,
  output logic [7:0]  out_periph_offset,
  output logic [7:0]  out_periph_data,
  output logic [15:0] out_stack_pointer
);
  import mdss_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  mdss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mdss_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_opcode         (in_opcode),
    .in_address        (in_address),
    .in_data           (in_data),
    .in_bit_index      (in_bit_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_read_data     (out_read_data),
    .out_fault_now     (out_fault_now),
    .out_fault_pending (out_fault_pending),
    .out_periph_target (out_periph_target),
    .out_periph_write  (out_periph_write),
    .out_periph_offset (out_periph_offset),
    .out_periph_data   (out_periph_data),
    .out_stack_pointer (out_stack_pointer),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule

>>> sim/testbench.sv
// testbench: directed and random requests, checked by table values or a data-space predictor
`timescale 1ns / 100ps

module testbench;
  import mdss_pkg::*;

  localparam logic [3:0]  OP_CODE_MAX = 4'hF;
  localparam int unsigned RANDOM_REQS = 900;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LONG_HOLD   = 600;

  typedef struct packed {
    logic [15:0] rd;
    logic        fnow;
    logic        fpend;
    logic [1:0]  tgt;
    logic        wr;
    logic [7:0]  off;
    logic [7:0]  pdat;
    logic [15:0] sp;
  } access_result_t;

  typedef struct packed {
    logic [3:0]     op;
    logic [15:0]    addr;
    logic [15:0]    data;
    logic [2:0]     bidx;
    logic           typed;
    access_result_t res;
  } dir_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  in_opcode = '0;
  logic [15:0] in_address = '0;
  logic [15:0] in_data = '0;
  logic [2:0]  in_bit_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_read_data;
  logic        out_fault_now;
  logic        out_fault_pending;
  logic [1:0]  out_periph_target;
  logic        out_periph_write;
  logic [7:0]  out_periph_offset;
  logic [7:0]  out_periph_data;
  logic [15:0] out_stack_pointer;

  mcu_data_space_stack_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_address        (in_address),
    .in_data           (in_data),
    .in_bit_index      (in_bit_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_read_data     (out_read_data),
    .out_fault_now     (out_fault_now),
    .out_fault_pending (out_fault_pending),
    .out_periph_target (out_periph_target),
    .out_periph_write  (out_periph_write),
    .out_periph_offset (out_periph_offset),
    .out_periph_data   (out_periph_data),
    .out_stack_pointer (out_stack_pointer)
  );

  // predictor state
  logic [7:0]  regs_m [REG_COUNT];
  logic [7:0]  mem_m [MEM_DEPTH];
  logic [15:0] sp_m;
  logic [7:0]  sreg_m;
  logic        fault_m;
  logic        hit_fault;
  logic [1:0]  fw_tgt;
  logic        fw_wr;
  logic [7:0]  fw_off;
  logic [7:0]  fw_dat;

  access_result_t expected_results[$];
  int unsigned    mismatches = 0;
  int unsigned    results_seen = 0;
  int unsigned    cycle_count = 0;
  logic           send_burst = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void model_reset();
    foreach (regs_m[i]) regs_m[i] = 8'h00;
    foreach (mem_m[i]) mem_m[i] = 8'h00;
    sp_m = TOP_ADDRESS;
    sreg_m = 8'h00;
    fault_m = 1'b0;
  endfunction

  function automatic logic [1:0] window_of(input logic [15:0] a, output logic [7:0] off);
    off = 8'h00;
    if (a == {8'h00, TMR_A} || a == {8'h00, TMR_C} ||
        (a >= {8'h00, TMR_B_LO} && a <= {8'h00, TMR_B_TOP})) begin
      off = a[7:0] - IO_BASE[7:0];
      return PT_TIMER;
    end
    if (a >= {8'h00, UART_HI_LO} && a <= {8'h00, UART_HI_TOP}) begin
      off = a[7:0] - UART_HI_LO;
      return PT_UART;
    end
    if (a >= {8'h00, UART_LO_LO} && a <= {8'h00, UART_LO_TOP}) begin
      off = a[7:0] - IO_BASE[7:0];
      return PT_UART;
    end
    return PT_NONE;
  endfunction

  function automatic logic [7:0] load_byte(input logic [15:0] a);
    logic [1:0] t;
    logic [7:0] off;
    if (a < REG_COUNT) return regs_m[a];
    if (a == ADDR_SPL) return sp_m[7:0];
    if (a == ADDR_SPH) return sp_m[15:8];
    if (a == ADDR_SREG) return sreg_m;
    t = window_of(a, off);
    if (t != PT_NONE) begin
      fw_tgt = t;
      fw_wr = 1'b0;
      fw_off = off;
      fw_dat = 8'h00;
      return 8'h00;
    end
    if (a > TOP_ADDRESS) begin
      fault_m = 1'b1;
      hit_fault = 1'b1;
      return 8'h00;
    end
    return mem_m[a];
  endfunction

  function automatic void store_byte(input logic [15:0] a, input logic [7:0] v);
    logic [1:0] t;
    logic [7:0] off;
    if (a < REG_COUNT) begin
      regs_m[a] = v;
      return;
    end
    if (a == ADDR_SPL) begin
      sp_m[7:0] = v;
      return;
    end
    if (a == ADDR_SPH) begin
      sp_m[15:8] = v;
      return;
    end
    if (a == ADDR_SREG) begin
      sreg_m = v;
      return;
    end
    t = window_of(a, off);
    if (t != PT_NONE) begin
      fw_tgt = t;
      fw_wr = 1'b1;
      fw_off = off;
      fw_dat = v;
      return;
    end
    if (a > TOP_ADDRESS) begin
      fault_m = 1'b1;
      hit_fault = 1'b1;
      return;
    end
    mem_m[a] = v;
  endfunction

  function automatic void stack_push(input logic [7:0] v);
    if (sp_m < STACK_FLOOR || sp_m > TOP_ADDRESS) begin
      fault_m = 1'b1;
      hit_fault = 1'b1;
      return;
    end
    store_byte(sp_m, v);
    sp_m = sp_m - 16'd1;
  endfunction

  function automatic logic [7:0] stack_pop();
    if (sp_m >= TOP_ADDRESS) begin
      fault_m = 1'b1;
      hit_fault = 1'b1;
      return 8'h00;
    end
    sp_m = sp_m + 16'd1;
    return load_byte(sp_m);
  endfunction

  function automatic access_result_t model_access(input logic [3:0] op, input logic [15:0] addr,
                                                  input logic [15:0] data, input logic [2:0] bidx);
    access_result_t r;
    logic [15:0]    rd;
    logic [15:0]    ba;
    logic [7:0]     v;
    logic [7:0]     hi;
    hit_fault = 1'b0;
    fw_tgt = PT_NONE;
    fw_wr = 1'b0;
    fw_off = 8'h00;
    fw_dat = 8'h00;
    rd = 16'h0000;
    case (op)
      OP_READ: rd = {8'h00, load_byte(addr)};
      OP_WRITE: store_byte(addr, data[7:0]);
      OP_PUSH: stack_push(data[7:0]);
      OP_POP: rd = {8'h00, stack_pop()};
      OP_PUSHW: begin
        stack_push(data[7:0]);
        stack_push(data[15:8]);
      end
      OP_POPW: begin
        hi = stack_pop();
        rd = {hi, stack_pop()};
      end
      OP_SETBIT, OP_CLRBIT: begin
        ba = IO_BASE + {10'd0, addr[5:0]};
        v = load_byte(ba);
        if (op == OP_SETBIT) begin
          v = v | (8'h01 << bidx);
        end else begin
          v = v & ~(8'h01 << bidx);
        end
        store_byte(ba, v);
      end
      OP_CLRF: fault_m = 1'b0;
      default: ;
    endcase
    r.rd = hit_fault ? 16'h0000 : rd;
    r.fnow = hit_fault;
    r.fpend = fault_m;
    r.tgt = fw_tgt;
    r.wr = fw_wr;
    r.off = fw_off;
    r.pdat = fw_dat;
    r.sp = sp_m;
    return r;
  endfunction

  task automatic offer_request(input logic [3:0] op, input logic [15:0] addr,
                               input logic [15:0] data, input logic [2:0] bidx);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_address <= addr;
    in_data <= data;
    in_bit_index <= bidx;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic pick_request(output logic [3:0] op, output logic [15:0] addr,
                              output logic [15:0] data, output logic [2:0] bidx);
    int unsigned r;
    int unsigned c;
    r = $urandom_range(0, 99);
    c = $urandom_range(0, 99);
    data = 16'($urandom);
    bidx = 3'($urandom_range(0, 7));
    if (c < 20) begin
      addr = 16'($urandom_range(0, REG_COUNT - 1));
    end else if (c < 28) begin
      case ($urandom_range(0, 4))
        0: addr = {8'h00, TMR_A};
        1: addr = {8'h00, TMR_C};
        2: addr = 16'($urandom_range(TMR_B_LO, TMR_B_TOP));
        3: addr = 16'($urandom_range(UART_LO_LO, UART_LO_TOP));
        default: addr = 16'($urandom_range(UART_HI_LO, UART_HI_TOP));
      endcase
    end else if (c < 34) begin
      addr = 16'($urandom_range(ADDR_SPL, ADDR_SREG));
    end else if (c < 90) begin
      addr = 16'($urandom_range(IO_BASE, TOP_ADDRESS));
    end else if (c < 96) begin
      addr = 16'($urandom_range(int'(TOP_ADDRESS) + 1, 16'hFFFF));
    end else begin
      addr = 16'($urandom);
    end
    if (r < 20) op = OP_PUSH;
    else if (r < 34) op = OP_POP;
    else if (r < 42) op = OP_PUSHW;
    else if (r < 50) op = OP_POPW;
    else if (r < 68) op = OP_READ;
    else if (r < 84) op = OP_WRITE;
    else if (r < 90) op = OP_SETBIT;
    else if (r < 95) op = OP_CLRBIT;
    else if (r < 97) op = OP_CLRF;
    else op = 4'($urandom_range(int'(OP_CLRF) + 1, OP_CODE_MAX));
    // bring a wild stack pointer back into the stack area most of the time
    if ((sp_m < STACK_FLOOR || sp_m > TOP_ADDRESS) && $urandom_range(0, 9) < 7) begin
      op = OP_WRITE;
      addr = ADDR_SPH;
      data[7:0] = 8'($urandom_range(STACK_FLOOR[15:8], TOP_ADDRESS[15:8]));
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch on %s in result %0d: expected %h, got %h", name, results_seen, want, got);
      end
    end
  endtask

  // result side
  initial begin
    int unsigned    hold;
    logic           burst;
    access_result_t e;
    burst = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) burst = !burst;
      hold = burst ? 0 : $urandom_range(0, 18);
      if (results_seen == 250) hold = LONG_HOLD;
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result %0d arrived with none expected", results_seen);
      end else begin
        e = expected_results.pop_front();
        check_field("read_data", e.rd, out_read_data);
        check_field("fault_now", {15'd0, e.fnow}, {15'd0, out_fault_now});
        check_field("fault_pending", {15'd0, e.fpend}, {15'd0, out_fault_pending});
        check_field("periph_target", {14'd0, e.tgt}, {14'd0, out_periph_target});
        check_field("periph_write", {15'd0, e.wr}, {15'd0, out_periph_write});
        check_field("periph_offset", {8'd0, e.off}, {8'd0, out_periph_offset});
        check_field("periph_data", {8'd0, e.pdat}, {8'd0, out_periph_data});
        check_field("stack_pointer", e.sp, out_stack_pointer);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("mcu_data_space_stack_unit verification failed");
    $finish;
  end

  // request side
  initial begin
    dir_row_t       dir_rows[$];
    access_result_t got;
    logic [3:0]     op;
    logic [15:0]    addr;
    logic [15:0]    data;
    logic [2:0]     bidx;

    dir_rows.push_back('{OP_READ, ADDR_SPL, 16'h0000, 3'd0, 1'b1,
                         '{16'h00FF, 1'b0, 1'b0, PT_NONE, 1'b0, 8'h00, 8'h00, 16'h08FF}});
    dir_rows.push_back('{OP_READ, ADDR_SPH, 16'h0000, 3'd0, 1'b1,
                         '{16'h0008, 1'b0, 1'b0, PT_NONE, 1'b0, 8'h00, 8'h00, 16'h08FF}});
    dir_rows.push_back('{OP_POP, 16'h0000, 16'h0000, 3'd0, 1'b1,
                         '{16'h0000, 1'b1, 1'b1, PT_NONE, 1'b0, 8'h00, 8'h00, 16'h08FF}});
    dir_rows.push_back('{OP_CLRF, 16'h0000, 16'h0000, 3'd0, 1'b1,
                         '{16'h0000, 1'b0, 1'b0, PT_NONE, 1'b0, 8'h00, 8'h00, 16'h08FF}});
    dir_rows.push_back('{OP_READ, 16'hFFFF, 16'h0000, 3'd0, 1'b1,
                         '{16'h0000, 1'b1, 1'b1, PT_NONE, 1'b0, 8'h00, 8'h00, 16'h08FF}});
    dir_rows.push_back('{OP_WRITE, 16'hFFFF, 16'hFFFF, 3'd7, 1'b1,
                         '{16'h0000, 1'b1, 1'b1, PT_NONE, 1'b0, 8'h00, 8'h00, 16'h08FF}});
    dir_rows.push_back('{OP_CLRF, 16'h0000, 16'h0000, 3'd0, 1'b1,
                         '{16'h0000, 1'b0, 1'b0, PT_NONE, 1'b0, 8'h00, 8'h00, 16'h08FF}});
    dir_rows.push_back('{OP_READ, 16'h00C6, 16'h0000, 3'd7, 1'b1,
                         '{16'h0000, 1'b0, 1'b0, PT_UART, 1'b0, 8'h06, 8'h00, 16'h08FF}});
    dir_rows.push_back('{OP_WRITE, 16'h0035, 16'h00A5, 3'd0, 1'b1,
                         '{16'h0000, 1'b0, 1'b0, PT_TIMER, 1'b1, 8'h15, 8'hA5, 16'h08FF}});
    dir_rows.push_back('{OP_WRITE, 16'h002D, 16'hFFFF, 3'd0, 1'b0, '0});
    dir_rows.push_back('{OP_PUSHW, 16'h0000, 16'hFFFF, 3'd0, 1'b0, '0});
    dir_rows.push_back('{OP_PUSH, 16'h0000, 16'h0000, 3'd0, 1'b0, '0});
    dir_rows.push_back('{OP_POPW, 16'h0000, 16'h0000, 3'd0, 1'b0, '0});
    dir_rows.push_back('{OP_POP, 16'h0000, 16'h0000, 3'd0, 1'b0, '0});
    // stack pointer at the floor, then a word push whose high half faults
    dir_rows.push_back('{OP_WRITE, ADDR_SPH, 16'h0001, 3'd0, 1'b0, '0});
    dir_rows.push_back('{OP_WRITE, ADDR_SPL, 16'hFF00, 3'd0, 1'b0, '0});
    dir_rows.push_back('{OP_PUSHW, 16'h0000, 16'h1234, 3'd0, 1'b0, '0});
    dir_rows.push_back('{OP_CLRF, 16'h0000, 16'h0000, 3'd0, 1'b0, '0});
    // one below the top, then a word pop whose low half faults
    dir_rows.push_back('{OP_WRITE, ADDR_SPH, 16'h0008, 3'd0, 1'b0, '0});
    dir_rows.push_back('{OP_WRITE, ADDR_SPL, 16'h00FE, 3'd0, 1'b0, '0});
    dir_rows.push_back('{OP_POPW, 16'h0000, 16'h0000, 3'd0, 1'b0, '0});
    dir_rows.push_back('{OP_SETBIT, 16'hFFFF, 16'h0000, 3'd7, 1'b0, '0});
    dir_rows.push_back('{OP_CLRBIT, 16'h0009, 16'h0000, 3'd0, 1'b0, '0});
    dir_rows.push_back('{OP_SETBIT, 16'h0015, 16'h0000, 3'd3, 1'b0, '0});
    dir_rows.push_back('{OP_WRITE, 16'h0000, 16'hFF5A, 3'd0, 1'b0, '0});
    dir_rows.push_back('{OP_READ, 16'h0000, 16'h0000, 3'd0, 1'b0, '0});
    dir_rows.push_back('{OP_WRITE, TOP_ADDRESS, 16'h0077, 3'd0, 1'b0, '0});
    dir_rows.push_back('{OP_READ, TOP_ADDRESS, 16'h0000, 3'd0, 1'b0, '0});
    dir_rows.push_back('{OP_CODE_MAX, 16'h1234, 16'h5678, 3'd5, 1'b0, '0});

    model_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      offer_request(dir_rows[i].op, dir_rows[i].addr, dir_rows[i].data, dir_rows[i].bidx);
      got = model_access(dir_rows[i].op, dir_rows[i].addr, dir_rows[i].data, dir_rows[i].bidx);
      expected_results.push_back(dir_rows[i].typed ? dir_rows[i].res : got);
    end

    repeat (RANDOM_REQS) begin
      pick_request(op, addr, data, bidx);
      offer_request(op, addr, data, bidx);
      expected_results.push_back(model_access(op, addr, data, bidx));
    end
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("mcu_data_space_stack_unit verification clean");
    end else begin
      $display("mcu_data_space_stack_unit verification failed");
    end
    $finish;
  end

endmodule
